// ----- rtl/core/msx_pkg.sv -----
package msx_pkg;

  // input function codes
  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_COUNT = 2'd2;
  localparam logic [1:0] FUNC_DRAW  = 2'd3;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_CAMERA_X   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CAMERA_Y   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SCREEN_W   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SCREEN_H   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_HFLIP_MASK = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_VFLIP_MASK = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TYPE_COUNT = 3'd6;

  // types reachable through the 5-bit type index
  localparam int MSX_TYPE_ADDR = 32;

  // queue depths between front, back and the result port
  localparam int MSX_CMD_DEPTH = 2;
  localparam int MSX_RES_DEPTH = 4;
  localparam int MSX_RES_CW    = $clog2(MSX_RES_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_LOAD,
    OP_COUNT,
    OP_DRAW
  } msx_op_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [4:0]        type_index;
    logic [2:0]        part_index;
    logic [7:0]        part_tile;
    logic signed [7:0] part_dx;
    logic signed [7:0] part_dy;
    logic [7:0]        part_attr;
    logic [3:0]        part_count;
    logic [1:0]        inst_flags;
    logic [7:0]        inst_anim_state;
    logic [15:0]       world_x;
    logic [15:0]       world_y;
  } msx_in_t;

  typedef struct packed {
    logic [7:0] oam_y;
    logic [7:0] oam_tile;
    logic [7:0] oam_attr;
    logic [7:0] oam_x;
    logic [5:0] oam_slot;
    logic       visible;
    logic       last_part;
  } msx_out_t;

  typedef struct packed {
    logic [15:0] camera_x;
    logic [15:0] camera_y;
    logic [8:0]  screen_width;
    logic [8:0]  screen_height;
    logic [7:0]  hflip_attr_mask;
    logic [7:0]  vflip_attr_mask;
    logic [5:0]  type_count;
  } msx_cfg_t;

  localparam msx_cfg_t CFG_RESET = '{
    camera_x:        16'd0,
    camera_y:        16'd0,
    screen_width:    9'd256,
    screen_height:   9'd240,
    hflip_attr_mask: 8'd64,
    vflip_attr_mask: 8'd128,
    type_count:      6'd0
  };

  // classified command between front and back
  typedef struct packed {
    msx_op_t     op;
    logic [4:0]  type_index;
    logic [2:0]  part_index;
    logic [31:0] part_word;    // tile, dx, dy, attr
    logic [3:0]  part_count;   // already saturated
    logic [1:0]  inst_flags;
    logic [7:0]  inst_anim_state;
    logic [15:0] world_x;
    logic [15:0] world_y;
  } msx_cmd_t;

endpackage

// ----- rtl/core/msx_ram.sv -----
module msx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/msx_fifo.sv -----
module msx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               din,
  input  logic                           pop,
  output logic [WIDTH-1:0]               dout,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH + 1)-1:0]   count
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign count   = cnt;
  assign dout    = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : PW'(wp + 1'b1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : PW'(rp + 1'b1);
      end
      cnt <= CW'(cnt + CW'(do_push) - CW'(do_pop));
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ----- rtl/core/msx_front.sv -----
module msx_front import msx_pkg::*; #(
  parameter int TYPE_SLOTS     = 32,
  parameter int PARTS_PER_TYPE = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  msx_in_t  item,
  output logic     full,
  input  logic [5:0] type_count,
  input  logic     cmd_pop,
  output msx_cmd_t cmd,
  output logic     cmd_empty
);

  msx_cmd_t   cmd_in;
  logic       keep;
  logic       type_ok;
  logic [3:0] cnt_sat;
  logic [$bits(msx_cmd_t)-1:0] cmd_bits;

  assign type_ok = 32'(item.type_index) < TYPE_SLOTS;
  assign cnt_sat = (32'(item.part_count) > PARTS_PER_TYPE) ? 4'(PARTS_PER_TYPE)
                                                           : item.part_count;

  // out-of-range loads and counts, and draws of unknown types, are dropped here
  always_comb begin
    cmd_in.op              = OP_FRAME;
    cmd_in.type_index      = item.type_index;
    cmd_in.part_index      = item.part_index;
    cmd_in.part_word       = {item.part_tile, item.part_dx, item.part_dy, item.part_attr};
    cmd_in.part_count      = cnt_sat;
    cmd_in.inst_flags      = item.inst_flags;
    cmd_in.inst_anim_state = item.inst_anim_state;
    cmd_in.world_x         = item.world_x;
    cmd_in.world_y         = item.world_y;
    keep                   = 1'b0;
    unique case (item.func)
      FUNC_FRAME: begin
        cmd_in.op = OP_FRAME;
        keep      = 1'b1;
      end
      FUNC_LOAD: begin
        cmd_in.op = OP_LOAD;
        keep      = type_ok && (32'(item.part_index) < PARTS_PER_TYPE);
      end
      FUNC_COUNT: begin
        cmd_in.op = OP_COUNT;
        keep      = type_ok;
      end
      FUNC_DRAW: begin
        cmd_in.op = OP_DRAW;
        keep      = type_ok && (6'(item.type_index) < type_count);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  msx_fifo #(
    .WIDTH ($bits(msx_cmd_t)),
    .DEPTH (MSX_CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .full  (full),
    .empty (cmd_empty),
    .count ()
  );

  assign cmd = msx_cmd_t'(cmd_bits);

endmodule

// ----- rtl/core/msx_back.sv -----
module msx_back import msx_pkg::*; #(
  parameter int TYPE_SLOTS     = 32,
  parameter int PARTS_PER_TYPE = 8,
  parameter int OAM_ENTRIES    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  msx_cfg_t              cfg,
  input  msx_cmd_t              cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  input  logic [MSX_RES_CW-1:0] res_count,
  output logic                  res_push,
  output msx_out_t              res
);

  localparam int CNT_DEPTH = TYPE_SLOTS < MSX_TYPE_ADDR ? TYPE_SLOTS : MSX_TYPE_ADDR;
  localparam int CIW       = CNT_DEPTH > 1 ? $clog2(CNT_DEPTH) : 1;
  localparam int CW        = $clog2(PARTS_PER_TYPE + 1);
  localparam int RDEPTH    = CNT_DEPTH * PARTS_PER_TYPE;
  localparam int AW        = $clog2(RDEPTH > 1 ? RDEPTH : 2);
  localparam int UW        = $clog2(OAM_ENTRIES + 1);
  localparam logic signed [15:0] CULL_LO = -16'sd8;

  typedef enum logic {IDLE, RUN} state_t;

  state_t        state;
  logic [CW-1:0] counts [CNT_DEPTH];
  logic [UW-1:0] oam_used;
  logic [CW-1:0] pi;
  logic [CW-1:0] pc;
  logic [AW-1:0] base_addr;
  logic [15:0]   base_x;
  logic [15:0]   base_y;
  logic          hflip;
  logic          vflip;
  logic          anim_nz;
  logic          rd_v;
  logic          rd_last;

  logic [CW-1:0] pc_sel;
  logic          issue;
  logic          is_last;
  logic          credit_ok;
  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic [15:0]        dx16;
  logic [15:0]        dy16;
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic               on_screen;
  logic               vis;
  logic [7:0]         slot_ext;

  assign pc_sel    = counts[cmd.type_index[CIW-1:0]];
  assign cmd_pop   = (state == IDLE) && !cmd_empty && !rd_v;
  // a read is issued only if its word is sure to find room in the result queue
  assign credit_ok = ({1'b0, res_count} + (MSX_RES_CW + 1)'(rd_v))
                     < (MSX_RES_CW + 1)'(MSX_RES_DEPTH);
  assign issue     = (state == RUN) && credit_ok;
  assign is_last   = (pi == CW'(pc - 1'b1));

  assign ram_we = cmd_pop && (cmd.op == OP_LOAD);
  assign waddr  = AW'(int'(cmd.type_index) * PARTS_PER_TYPE + int'(cmd.part_index));
  assign raddr  = AW'(base_addr + AW'(pi));

  msx_ram #(
    .WIDTH (32),
    .DEPTH (RDEPTH)
  ) u_part_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (cmd.part_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  // flipped offset -d-8 folds into base (-7) plus the inverted offset
  always_comb begin
    dx16      = {{8{rdata[23]}}, rdata[23:16]};
    dy16      = {{8{rdata[15]}}, rdata[15:8]};
    sx        = $signed(16'(base_x + (hflip ? ~dx16 : dx16)));
    sy        = $signed(16'(base_y + (vflip ? ~dy16 : dy16)));
    on_screen = !(sx <= CULL_LO || sy <= CULL_LO ||
                  sx >= $signed({7'd0, cfg.screen_width}) ||
                  sy >= $signed({7'd0, cfg.screen_height}));
    vis       = on_screen && (oam_used < UW'(OAM_ENTRIES));
    slot_ext  = 8'(oam_used);

    res.oam_y     = sy[7:0];
    res.oam_tile  = 8'(rdata[31:24] + {7'd0, anim_nz});
    res.oam_attr  = rdata[7:0] ^ (hflip ? cfg.hflip_attr_mask : 8'd0)
                               ^ (vflip ? cfg.vflip_attr_mask : 8'd0);
    res.oam_x     = sx[7:0];
    res.oam_slot  = vis ? slot_ext[5:0] : 6'd0;
    res.visible   = vis;
    res.last_part = rd_last;
  end

  assign res_push = rd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      oam_used <= '0;
      rd_v     <= 1'b0;
      pi       <= '0;
      pc       <= '0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        counts[i] <= '0;
      end
    end else begin
      rd_v <= issue;
      if (issue) begin
        rd_last <= is_last;
      end
      if (rd_v && vis) begin
        oam_used <= UW'(oam_used + 1'b1);
      end
      unique case (state)
        IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_FRAME: oam_used <= '0;
              OP_COUNT: counts[cmd.type_index[CIW-1:0]] <= CW'(cmd.part_count);
              OP_DRAW: begin
                if (pc_sel != '0) begin
                  pc        <= pc_sel;
                  pi        <= '0;
                  base_addr <= AW'(int'(cmd.type_index) * PARTS_PER_TYPE);
                  base_x    <= 16'(cmd.world_x - cfg.camera_x
                                   - (cmd.inst_flags[0] ? 16'd7 : 16'd0));
                  base_y    <= 16'(cmd.world_y - cfg.camera_y
                                   - (cmd.inst_flags[1] ? 16'd7 : 16'd0));
                  hflip     <= cmd.inst_flags[0];
                  vflip     <= cmd.inst_flags[1];
                  anim_nz   <= (cmd.inst_anim_state != 8'd0);
                  state     <= RUN;
                end
              end
              default: ;
            endcase
          end
        end
        RUN: begin
          if (issue) begin
            pi <= CW'(pi + 1'b1);
            if (is_last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_oam_bound: assert property (@(posedge clk) disable iff (rst)
    oam_used <= UW'(OAM_ENTRIES))
    else $error("oam slot counter past the table size");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_count < MSX_RES_CW'(MSX_RES_DEPTH))
    else $error("result word pushed into a full queue");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_push && res.last_part |-> state == IDLE)
    else $error("last part delivered while the draw still issues reads");

  a_oam_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && oam_used != $past(oam_used)
      |-> oam_used == UW'($past(oam_used) + 1'b1) || oam_used == '0)
    else $error("oam slot counter jumped");
`endif

endmodule

// ----- rtl/core/metasprite_oam_expander.sv -----
// metasprite to oam expander
// input queue: push an item while full is low; one word per cycle is taken.
// load-part and set-count words fill the part table and the per-type counts,
// begin-frame restarts oam slot numbering, and a draw word expands into one
// result per stored part of its type, in part order, the final one flagged
// by last_part. culled parts and parts past a full oam come out with visible
// low and slot zero.
// result queue: while empty is low the oldest result sits on result; pop takes
// it. results wait in a four-deep queue, so the part reader keeps running
// while the receiver stalls, halting once results queued or in flight fill it.
// a draw's path: command queue, run state, part table read, result queue.
// throughput: a draw of n parts makes n part table reads, one per cycle
// while the result queue has room; the next word waits until they are out.
// config: cfg_write with cfg_index and cfg_data, one register per cycle,
// only while no draw is in flight.
// reset: registers to their defaults, all part counts and the slot counter
// to zero, queues emptied; the part table keeps its contents.
module metasprite_oam_expander import msx_pkg::*; #(
  parameter int TYPE_SLOTS     = 32,
  parameter int PARTS_PER_TYPE = 8,
  parameter int OAM_ENTRIES    = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msx_in_t           item,
  output logic              full,
  input  logic              pop,
  output msx_out_t          result,
  output logic              empty,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  msx_cfg_t              cfg;
  msx_cmd_t              cmd;
  logic                  cmd_empty;
  logic                  cmd_pop;
  logic                  res_push;
  msx_out_t              res;
  logic [MSX_RES_CW-1:0] res_count;
  logic [$bits(msx_out_t)-1:0] res_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CAMERA_X:   cfg.camera_x        <= cfg_data;
        CFG_CAMERA_Y:   cfg.camera_y        <= cfg_data;
        CFG_SCREEN_W:   cfg.screen_width    <= cfg_data[8:0];
        CFG_SCREEN_H:   cfg.screen_height   <= cfg_data[8:0];
        CFG_HFLIP_MASK: cfg.hflip_attr_mask <= cfg_data[7:0];
        CFG_VFLIP_MASK: cfg.vflip_attr_mask <= cfg_data[7:0];
        CFG_TYPE_COUNT: cfg.type_count      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  msx_front #(
    .TYPE_SLOTS     (TYPE_SLOTS),
    .PARTS_PER_TYPE (PARTS_PER_TYPE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .type_count (cfg.type_count),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty)
  );

  msx_back #(
    .TYPE_SLOTS     (TYPE_SLOTS),
    .PARTS_PER_TYPE (PARTS_PER_TYPE),
    .OAM_ENTRIES    (OAM_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res)
  );

  msx_fifo #(
    .WIDTH ($bits(msx_out_t)),
    .DEPTH (MSX_RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .pop   (pop),
    .dout  (res_bits),
    .full  (),
    .empty (empty),
    .count (res_count)
  );

  assign result = msx_out_t'(res_bits);

endmodule

// ----- verif/metasprite_oam_expander_test.sv -----
module metasprite_oam_expander_test import msx_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TYPES       = 32;
  localparam int PARTS       = 8;
  localparam int OAM_SLOTS   = 64;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0]        tile;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [7:0]        attr;
  } part_rec_t;

  // expected oam words, worked out from every accepted input word
  class oam_predictor;
    part_rec_t   parts [TYPES*PARTS];
    logic [3:0]  part_cnt [TYPES];
    int unsigned slots_used;
    logic [15:0] cam_x, cam_y;
    logic [8:0]  scr_w, scr_h;
    logic [7:0]  hmask, vmask;
    logic [5:0]  type_limit;
    msx_out_t    sprites_due[$];
    int          mismatches, sprites_seen, shown, dropped_full;

    function new();
      foreach (part_cnt[i]) part_cnt[i] = '0;
      foreach (parts[i]) parts[i] = '0;
      slots_used = 0;
      cam_x = CFG_RESET.camera_x;
      cam_y = CFG_RESET.camera_y;
      scr_w = CFG_RESET.screen_width;
      scr_h = CFG_RESET.screen_height;
      hmask = CFG_RESET.hflip_attr_mask;
      vmask = CFG_RESET.vflip_attr_mask;
      type_limit = CFG_RESET.type_count;
      mismatches = 0;
      sprites_seen = 0;
      shown = 0;
      dropped_full = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
      case (idx)
        CFG_CAMERA_X:   cam_x = d;
        CFG_CAMERA_Y:   cam_y = d;
        CFG_SCREEN_W:   scr_w = d[8:0];
        CFG_SCREEN_H:   scr_h = d[8:0];
        CFG_HFLIP_MASK: hmask = d[7:0];
        CFG_VFLIP_MASK: vmask = d[7:0];
        CFG_TYPE_COUNT: type_limit = d[5:0];
        default: ;
      endcase
    endfunction

    function void take_item(msx_in_t w);
      part_rec_t   pr;
      int          rx, ry, sx, sy, base;
      logic [15:0] ux, uy;
      logic [7:0]  a;
      bit          vis;
      msx_out_t    o;
      case (w.func)
        FUNC_FRAME: slots_used = 0;
        FUNC_LOAD: begin
          parts[int'(w.type_index)*PARTS + int'(w.part_index)] =
            '{w.part_tile, w.part_dx, w.part_dy, w.part_attr};
        end
        FUNC_COUNT: part_cnt[w.type_index] = (w.part_count > PARTS) ? 4'(PARTS) : w.part_count;
        FUNC_DRAW: begin
          if (w.type_index < type_limit) begin
            base = int'(w.type_index) * PARTS;
            for (int p = 0; p < part_cnt[w.type_index]; p++) begin
              pr = parts[base + p];
              rx = int'($signed(pr.dx));
              ry = int'($signed(pr.dy));
              a = pr.attr;
              if (w.inst_flags[0]) begin
                rx = -rx - 8;
                a ^= hmask;
              end
              if (w.inst_flags[1]) begin
                ry = -ry - 8;
                a ^= vmask;
              end
              ux = 16'(int'(w.world_x) + rx - int'(cam_x));
              uy = 16'(int'(w.world_y) + ry - int'(cam_y));
              sx = int'($signed(ux));
              sy = int'($signed(uy));
              vis = !(sx + 8 <= 0 || sy + 8 <= 0 || sx >= int'(scr_w) || sy >= int'(scr_h));
              if (slots_used >= OAM_SLOTS) begin
                vis = 1'b0;
                dropped_full++;
              end
              o.oam_y     = uy[7:0];
              o.oam_tile  = pr.tile + 8'(w.inst_anim_state != 8'd0);
              o.oam_attr  = a;
              o.oam_x     = ux[7:0];
              o.oam_slot  = vis ? 6'(slots_used) : 6'd0;
              o.visible   = vis;
              o.last_part = (p + 1 == int'(part_cnt[w.type_index]));
              sprites_due.push_back(o);
              if (vis) begin
                slots_used++;
                shown++;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_sprite(msx_out_t got);
      msx_out_t want;
      if (sprites_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected oam word: y=%0d tile=%0d attr=%0d x=%0d slot=%0d vis=%0b last=%0b",
                   got.oam_y, got.oam_tile, got.oam_attr, got.oam_x, got.oam_slot,
                   got.visible, got.last_part);
      end else begin
        want = sprites_due.pop_front();
        sprites_seen++;
        if (got.oam_y !== want.oam_y || got.oam_tile !== want.oam_tile ||
            got.oam_attr !== want.oam_attr || got.oam_x !== want.oam_x ||
            got.oam_slot !== want.oam_slot || got.visible !== want.visible ||
            got.last_part !== want.last_part) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("oam word %0d mismatch", sprites_seen);
            $display("  expected y=%0d tile=%0d attr=%0d x=%0d slot=%0d vis=%0b last=%0b",
                     want.oam_y, want.oam_tile, want.oam_attr, want.oam_x, want.oam_slot,
                     want.visible, want.last_part);
            $display("  actual   y=%0d tile=%0d attr=%0d x=%0d slot=%0d vis=%0b last=%0b",
                     got.oam_y, got.oam_tile, got.oam_attr, got.oam_x, got.oam_slot,
                     got.visible, got.last_part);
          end
        end
      end
    endfunction

    function int waiting();
      return sprites_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              push      = 1'b0;
  msx_in_t           item      = '0;
  logic              full;
  logic              pop       = 1'b0;
  msx_out_t          result;
  logic              empty;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_CAMERA_X;
  logic [CFG_DW-1:0] cfg_data  = '0;

  oam_predictor board = new();
  bit part_loaded [TYPES*PARTS];
  bit calm = 1'b0;
  int items_sent = 0;
  int draws_sent = 0;
  int cycles = 0;

  metasprite_oam_expander #(
    .TYPE_SLOTS(TYPES),
    .PARTS_PER_TYPE(PARTS),
    .OAM_ENTRIES(OAM_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .pop(pop),
    .result(result),
    .empty(empty),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("metasprite_oam_expander_test failed");
    $finish;
  end

  // result side: pop with random stall bursts, check every accepted word
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) board.check_sprite(result);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // number of parts loaded in a row from part zero
  function automatic int loaded_prefix(int t);
    int n;
    n = 0;
    while (n < PARTS && part_loaded[t*PARTS + n]) n++;
    return n;
  endfunction

  // a draw must never read a part that was never loaded
  function automatic bit draw_safe(int t);
    if (t >= int'(board.type_limit)) return 1'b1;
    return int'(board.part_cnt[t]) <= loaded_prefix(t);
  endfunction

  function automatic msx_in_t word_of(logic [1:0] f, int t, int p, int tile, int dx, int dy,
                                      int attr, int cnt, int flags, int anim, int wx, int wy);
    msx_in_t w;
    w.func            = f;
    w.type_index      = 5'(t);
    w.part_index      = 3'(p);
    w.part_tile       = 8'(tile);
    w.part_dx         = 8'(dx);
    w.part_dy         = 8'(dy);
    w.part_attr       = 8'(attr);
    w.part_count      = 4'(cnt);
    w.inst_flags      = 2'(flags);
    w.inst_anim_state = 8'(anim);
    w.world_x         = 16'(wx);
    w.world_y         = 16'(wy);
    return w;
  endfunction

  function automatic msx_in_t make_item();
    msx_in_t     w;
    logic [95:0] r;
    int          t, roll, off;
    r = {$urandom(), $urandom(), $urandom()};
    w = r[87:0];
    roll = $urandom_range(0, 99);
    // most traffic lands on a few low types so draws find loaded parts
    t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TYPES-1) : $urandom_range(0, 7);
    w.type_index = 5'(t);
    if (roll < 5) begin
      w.func = FUNC_FRAME;
    end else if (roll < 35) begin
      w.func = FUNC_LOAD;
      if ($urandom_range(0, 9) < 6 && loaded_prefix(t) < PARTS)
        w.part_index = 3'(loaded_prefix(t));
    end else if (roll < 45) begin
      w.func = FUNC_COUNT;
      if ($urandom_range(0, 9) < 7) w.part_count = 4'(loaded_prefix(t));
    end else if (!draw_safe(t)) begin
      w.func = FUNC_COUNT;
      w.part_count = 4'(loaded_prefix(t));
    end else begin
      w.func = FUNC_DRAW;
      if ($urandom_range(0, 4) != 0) begin
        off = $urandom_range(0, board.scr_w + 40) - 24;
        w.world_x = 16'(int'(board.cam_x) + off);
        off = $urandom_range(0, board.scr_h + 40) - 24;
        w.world_y = 16'(int'(board.cam_y) + off);
      end
      if ($urandom_range(0, 1) == 0) w.inst_anim_state = 8'd0;
    end
    return w;
  endfunction

  task automatic send(input msx_in_t w);
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full !== 1'b0);
    board.take_item(w);
    if (w.func == FUNC_LOAD) part_loaded[int'(w.type_index)*PARTS + int'(w.part_index)] = 1'b1;
    items_sent++;
    if (w.func == FUNC_DRAW) draws_sent++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      send(make_item());
    end
  endtask

  // hold the sender until every expected word is out, then let stray words finish
  task automatic settle();
    push <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(val);
    @(posedge clk);
    board.set_reg(idx, CFG_DW'(val));
  endtask

  task automatic apply_setting(input int unsigned cx, cy, sw, sh, hm, vm, tc);
    write_reg(CFG_CAMERA_X, cx);
    write_reg(CFG_CAMERA_Y, cy);
    write_reg(CFG_SCREEN_W, sw);
    write_reg(CFG_SCREEN_H, sh);
    write_reg(CFG_HFLIP_MASK, hm);
    write_reg(CFG_VFLIP_MASK, vm);
    write_reg(CFG_TYPE_COUNT, tc);
    cfg_write <= 1'b0;
  endtask

  task automatic run_directed();
    int tiles [PARTS] = '{255, 0, 90, 128, 1, 254, 127, 15};
    int dxs   [PARTS] = '{-128, 127, 0, -1, -8, 8, 100, -100};
    int dys   [PARTS] = '{127, -128, 0, -8, -1, 64, -64, 7};
    int attrs [PARTS] = '{0, 255, 165, 15, 240, 1, 128, 64};
    // type 1 gets eight parts spanning the field extremes
    for (int p = 0; p < PARTS; p++)
      send(word_of(FUNC_LOAD, 1, p, tiles[p], dxs[p], dys[p], attrs[p], 0, 0, 0, 0, 0));
    // count above eight saturates
    send(word_of(FUNC_COUNT, 1, 0, 0, 0, 0, 0, 15, 0, 0, 0, 0));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 0, 0, 100, 100));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 1, 255, 100, 100));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 2, 1, 0, 0));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 3, 0, 65535, 65535));
    // type with no parts
    send(word_of(FUNC_DRAW, 5, 0, 0, 0, 0, 0, 0, 0, 0, 50, 50));
    send(word_of(FUNC_COUNT, 1, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 0, 7, 248, 232));
    send(word_of(FUNC_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 1, 0, 100, 100));
    send(word_of(FUNC_COUNT, 1, 0, 0, 0, 0, 0, 8, 0, 0, 0, 0));
    send(word_of(FUNC_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(word_of(FUNC_DRAW, 1, 0, 0, 0, 0, 0, 0, 0, 0, 120, 110));
    // type 31 sits at the type limit, so its draw yields nothing
    send(word_of(FUNC_LOAD, 31, 0, 200, 4, 4, 3, 0, 0, 0, 0, 0));
    send(word_of(FUNC_COUNT, 31, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    send(word_of(FUNC_DRAW, 31, 0, 0, 0, 0, 0, 0, 0, 0, 40, 40));
  endtask

  initial begin
    int errors;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_setting(0, 0, 256, 240, 64, 128, 31);
    run_directed();
    settle();

    apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535), 511, 511, 255, 255, 16);
    run_random(60);
    settle();
    run_random(40);
    settle();

    apply_setting(65535, 65535, 1, 1, 0, 0, 32);
    run_random(40);
    settle();

    apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 511),
                  $urandom_range(1, 511), $urandom_range(0, 255), $urandom_range(0, 255), 0);
    run_random(15);
    settle();

    apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 511),
                  $urandom_range(1, 511), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(1, 32));
    run_random(40);
    calm = 1'b1;
    run_random(40);
    settle();

    errors = board.mismatches + board.waiting();
    $display("%0d input words sent, %0d of them draws, over five register settings",
             items_sent, draws_sent);
    $display("%0d oam words checked: %0d placed, %0d dropped on a full oam, %0d mismatches",
             board.sprites_seen, board.shown, board.dropped_full, board.mismatches);
    if (errors == 0)
      $display("metasprite_oam_expander_test passed");
    else
      $display("metasprite_oam_expander_test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/msx_pkg.sv
rtl/core/msx_ram.sv
rtl/core/msx_fifo.sv
rtl/core/msx_front.sv
rtl/core/msx_back.sv
rtl/core/metasprite_oam_expander.sv
verif/metasprite_oam_expander_test.sv
